### rtl/rrc_pkg.sv
// Shared constants and coefficient lookup for the 2x interpolating RRC filter.
package rrc_pkg;

	localparam int TAP_COUNT_DEF    = 21;
	localparam int SAMPLE_WIDTH_DEF = 16;
	localparam int UPSAMPLE_FACTOR  = 2;
	localparam int COEF_W           = 16;
	localparam int FRAC_BITS        = 15;
	localparam int HALF_LEN         = 11;

	// outer taps toward the center tap, Q1.15
	localparam logic signed [COEF_W-1:0] RRC_HALF [HALF_LEN] = '{
		-16'sd15, 16'sd116, -16'sd234, 16'sd248, 16'sd70, -16'sd348,
		16'sd983, -16'sd1738, -16'sd2459, 16'sd13409, 16'sd26336
	};

	// symmetric tap k of an n-tap filter; taps beyond the half table are zero
	function automatic logic signed [COEF_W-1:0] tap_coef(input int k, input int n);
		int m;
		m = (k < (n - 1 - k)) ? k : (n - 1 - k);
		if ((m < 0) || (m >= HALF_LEN)) begin
			return '0;
		end
		return RRC_HALF[m];
	endfunction

endpackage

### rtl/rrc_cell.sv
// Transposed-form FIR cell: adds its tap product to the partial sum from its neighbor.
module rrc_cell
	import rrc_pkg::*;
#(
	parameter int                       SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
	parameter int                       ACC_W        = 40,
	parameter logic signed [COEF_W-1:0] COEF         = '0
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic signed [SAMPLE_WIDTH-1:0] x_i,
	input  logic signed [SAMPLE_WIDTH-1:0] x_q,
	input  logic signed [ACC_W-1:0]        sum_in_i,
	input  logic signed [ACC_W-1:0]        sum_in_q,
	output logic signed [ACC_W-1:0]        sum_out_i,
	output logic signed [ACC_W-1:0]        sum_out_q
);

	localparam int PROD_W = SAMPLE_WIDTH + COEF_W;

	logic signed [PROD_W-1:0] prod_i;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [ACC_W-1:0]  sum_i_q;
	logic signed [ACC_W-1:0]  sum_q_q;

	assign prod_i = x_i * COEF;
	assign prod_q = x_q * COEF;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_i_q <= '0;
			sum_q_q <= '0;
		end else if (en) begin
			sum_i_q <= sum_in_i + ACC_W'(prod_i);
			sum_q_q <= sum_in_q + ACC_W'(prod_q);
		end
	end

	assign sum_out_i = sum_i_q;
	assign sum_out_q = sum_q_q;

endmodule

### rtl/rrc_interpolating_fir_x2.sv
// Top level: 2x interpolating complex RRC FIR built as a chain of transposed-form cells.
// An accepted sample's first output word goes through the cell registers, then the output register.
// Throughput: input waits for every phase of the prior word; one output word per cycle
// while the skid is empty; a tlast word adds TAP_COUNT-1 tail outputs, one per cycle, input held off.
// Rate is set by the one-product-per-cell chain step per upsampled output.
// Reset clears the delay line, sequencer and output buffer at once.
module rrc_interpolating_fir_x2
	import rrc_pkg::*;
#(
	parameter int TAP_COUNT    = TAP_COUNT_DEF,
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
	localparam int DATA_W      = ((2 * SAMPLE_WIDTH + 7) / 8) * 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [DATA_W-1:0] s_tdata,   // sample_i, sample_q
	input  logic              s_tlast,   // end_of_frame
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [DATA_W-1:0] m_tdata,   // filtered_i, filtered_q
	output logic [0:0]        m_tuser,   // saturated
	output logic              m_tlast    // last_of_frame
);

	localparam int ACC_W   = SAMPLE_WIDTH + COEF_W + $clog2(TAP_COUNT);
	localparam int TAIL_W  = $clog2(TAP_COUNT);
	localparam int PHASE_W = $clog2(UPSAMPLE_FACTOR);

	localparam logic signed [ACC_W-1:0] RND  = ACC_W'(2 ** (FRAC_BITS - 1));
	localparam logic signed [ACC_W-1:0] MAXV = ACC_W'(2 ** (SAMPLE_WIDTH - 1) - 1);
	localparam logic signed [ACC_W-1:0] MINV = -MAXV - ACC_W'(1);
	localparam logic [PHASE_W-1:0] LAST_PHASE = PHASE_W'(UPSAMPLE_FACTOR - 1);

	// sequencer
	logic [PHASE_W-1:0] phase_q;
	logic [TAIL_W-1:0]  tail_q;
	logic               eof_q;
	logic               adv;
	logic               in_acc;
	logic               step;
	logic               step_last;

	// chain
	logic signed [SAMPLE_WIDTH-1:0] x_i;
	logic signed [SAMPLE_WIDTH-1:0] x_q;
	logic signed [ACC_W-1:0]        sum_i [TAP_COUNT+1];
	logic signed [ACC_W-1:0]        sum_q [TAP_COUNT+1];
	logic                           valid_s1;
	logic                           last_s1;

	// output buffer
	logic                    push;
	logic                    pop;
	logic [SAMPLE_WIDTH-1:0] res_i;
	logic [SAMPLE_WIDTH-1:0] res_q;
	logic                    res_sat;
	logic                    sat_i;
	logic                    sat_q;
	logic [SAMPLE_WIDTH-1:0] out_i_q;
	logic [SAMPLE_WIDTH-1:0] out_q_q;
	logic                    out_sat_q;
	logic                    out_last_q;
	logic                    out_v_q;
	logic [SAMPLE_WIDTH-1:0] skid_i_q;
	logic [SAMPLE_WIDTH-1:0] skid_q_q;
	logic                    skid_sat_q;
	logic                    skid_last_q;
	logic                    skid_v_q;

	function automatic logic [SAMPLE_WIDTH:0] rnd_sat(input logic signed [ACC_W-1:0] acc);
		logic signed [ACC_W-1:0] biased;
		logic signed [ACC_W-1:0] shifted;
		biased  = acc + RND;
		shifted = biased >>> FRAC_BITS;
		if (shifted > MAXV) begin
			return {1'b1, MAXV[SAMPLE_WIDTH-1:0]};
		end
		if (shifted < MINV) begin
			return {1'b1, MINV[SAMPLE_WIDTH-1:0]};
		end
		return {1'b0, shifted[SAMPLE_WIDTH-1:0]};
	endfunction

	assign adv       = !skid_v_q;
	assign s_tready  = adv && (phase_q == '0) && (tail_q == '0);
	assign in_acc    = s_tvalid && s_tready;
	assign step      = in_acc || (adv && ((phase_q != '0) || (tail_q != '0)));
	assign step_last = (phase_q == '0) && (tail_q == TAIL_W'(1));

	assign x_i = in_acc ? s_tdata[SAMPLE_WIDTH-1:0] : '0;
	assign x_q = in_acc ? s_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			tail_q  <= '0;
			eof_q   <= 1'b0;
		end else if (step) begin
			if (in_acc) begin
				phase_q <= (UPSAMPLE_FACTOR > 1) ? PHASE_W'(1) : '0;
				eof_q   <= s_tlast;
			end else if (phase_q != '0) begin
				phase_q <= (phase_q == LAST_PHASE) ? '0 : phase_q + PHASE_W'(1);
			end else begin
				tail_q <= tail_q - TAIL_W'(1);
			end
			if ((phase_q == LAST_PHASE) && (phase_q != '0) && eof_q) begin
				tail_q <= TAIL_W'(TAP_COUNT - 1);
				eof_q  <= 1'b0;
			end
		end
	end

	assign sum_i[TAP_COUNT] = '0;
	assign sum_q[TAP_COUNT] = '0;

	for (genvar k = 0; k < TAP_COUNT; k++) begin : g_cell
		rrc_cell #(
			.SAMPLE_WIDTH (SAMPLE_WIDTH),
			.ACC_W        (ACC_W),
			.COEF         (tap_coef(k, TAP_COUNT))
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (step),
			.x_i       (x_i),
			.x_q       (x_q),
			.sum_in_i  (sum_i[k+1]),
			.sum_in_q  (sum_q[k+1]),
			.sum_out_i (sum_i[k]),
			.sum_out_q (sum_q[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			last_s1  <= 1'b0;
		end else if (adv) begin
			valid_s1 <= step;
			last_s1  <= step && step_last;
		end
	end

	always_comb begin
		{sat_i, res_i} = rnd_sat(sum_i[0]);
		{sat_q, res_q} = rnd_sat(sum_q[0]);
		res_sat        = sat_i || sat_q;
	end

	assign push = valid_s1 && adv;
	assign pop  = out_v_q && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (skid_v_q) begin
				if (pop) begin
					out_v_q  <= 1'b1;
					skid_v_q <= 1'b0;
				end
			end else if (push) begin
				if (!out_v_q || pop) begin
					out_v_q <= 1'b1;
				end else begin
					skid_v_q <= 1'b1;
				end
			end else if (pop) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (pop) begin
				out_i_q    <= skid_i_q;
				out_q_q    <= skid_q_q;
				out_sat_q  <= skid_sat_q;
				out_last_q <= skid_last_q;
			end
		end else if (push) begin
			if (!out_v_q || pop) begin
				out_i_q    <= res_i;
				out_q_q    <= res_q;
				out_sat_q  <= res_sat;
				out_last_q <= last_s1;
			end else begin
				skid_i_q    <= res_i;
				skid_q_q    <= res_q;
				skid_sat_q  <= res_sat;
				skid_last_q <= last_s1;
			end
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = DATA_W'({out_q_q, out_i_q});
	assign m_tuser  = out_sat_q;
	assign m_tlast  = out_last_q;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid word held while output register empty");

	a_eof_armed: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tlast) |=> (eof_q && (phase_q != '0)))
		else $error("end of frame not armed after accept");

	a_no_tail_mid_sample: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != '0) |-> (tail_q == '0))
		else $error("tail count running during a sample's zero phase");

endmodule

### tb/rrc_fir_checker.sv
`timescale 1ns / 100ps
// Checker for the 2x interpolating RRC filter: predicts every output word and compares.
module rrc_fir_checker
	import rrc_pkg::*;
#(
	parameter int DATA_W = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	input  logic              s_tready,
	input  logic [DATA_W-1:0] s_tdata,   // sample_i, sample_q
	input  logic              s_tlast,   // end_of_frame
	input  logic              m_tvalid,
	input  logic              m_tready,
	input  logic [DATA_W-1:0] m_tdata,   // filtered_i, filtered_q
	input  logic [0:0]        m_tuser,   // saturated
	input  logic              m_tlast,   // last_of_frame
	output int                fails,
	output int                pending
);

	localparam int SW    = SAMPLE_WIDTH_DEF;
	localparam int NTAP  = TAP_COUNT_DEF;
	localparam int HIST  = (NTAP - 1) / UPSAMPLE_FACTOR;
	localparam int NHALF = 11;
	localparam longint MAXV = (longint'(1) <<< (SW - 1)) - 1;
	localparam longint MINV = -MAXV - 1;

	// outer taps toward the center tap, Q1.15
	localparam longint FOLD_TAPS [NHALF] = '{
		-15, 116, -234, 248, 70, -348, 983, -1738, -2459, 13409, 26336
	};

	typedef struct packed {
		logic signed [SW-1:0] fi;
		logic signed [SW-1:0] fq;
		logic                 sat;
		logic                 last;
	} filt_word_t;

	logic signed [SW-1:0] hist_i [HIST];
	logic signed [SW-1:0] hist_q [HIST];
	filt_word_t           expected_words [$];

	initial begin
		fails   = 0;
		pending = 0;
		for (int a = 0; a < HIST; a++) begin
			hist_i[a] = '0;
			hist_q[a] = '0;
		end
	end

	function automatic longint tap_weight(input int k);
		int m;
		m = (k < NTAP - 1 - k) ? k : NTAP - 1 - k;
		if (m < 0 || m >= NHALF) begin
			return 0;
		end
		return FOLD_TAPS[m];
	endfunction

	// Q1.15 x Q1.15 sum back to Q1.15, round half up
	function automatic longint round_q14(input longint acc);
		return (acc + 16384) >>> 15;
	endfunction

	function automatic filt_word_t branch_out(input logic signed [SW-1:0] ci,
			input logic signed [SW-1:0] cq, input int phase, input logic last);
		filt_word_t w;
		longint acc_i, acc_q, si, sq, c, ri, rq;
		int age;
		acc_i = 0;
		acc_q = 0;
		for (int j = phase; j < NTAP; j += UPSAMPLE_FACTOR) begin
			age = j / UPSAMPLE_FACTOR;
			if (age == 0) begin
				si = ci;
				sq = cq;
			end else if (age <= HIST) begin
				si = hist_i[age-1];
				sq = hist_q[age-1];
			end else begin
				si = 0;
				sq = 0;
			end
			c = tap_weight(j);
			acc_i += c * si;
			acc_q += c * sq;
		end
		ri = round_q14(acc_i);
		rq = round_q14(acc_q);
		w.sat  = (ri > MAXV) || (ri < MINV) || (rq > MAXV) || (rq < MINV);
		w.fi   = (ri > MAXV) ? MAXV[SW-1:0] : (ri < MINV) ? MINV[SW-1:0] : ri[SW-1:0];
		w.fq   = (rq > MAXV) ? MAXV[SW-1:0] : (rq < MINV) ? MINV[SW-1:0] : rq[SW-1:0];
		w.last = last;
		return w;
	endfunction

	task automatic shift_in(input logic signed [SW-1:0] ci, input logic signed [SW-1:0] cq);
		for (int a = HIST - 1; a > 0; a--) begin
			hist_i[a] = hist_i[a-1];
			hist_q[a] = hist_q[a-1];
		end
		hist_i[0] = ci;
		hist_q[0] = cq;
	endtask

	task automatic predict_sample(input logic signed [SW-1:0] ci,
			input logic signed [SW-1:0] cq, input logic eof);
		int n;
		for (int p = 0; p < UPSAMPLE_FACTOR; p++) begin
			expected_words.push_back(branch_out(ci, cq, p, 1'b0));
		end
		shift_in(ci, cq);
		if (eof) begin
			n = 0;
			while (n < NTAP - 1) begin
				for (int p = 0; p < UPSAMPLE_FACTOR && n < NTAP - 1; p++) begin
					n++;
					expected_words.push_back(branch_out('0, '0, p, n == NTAP - 1));
				end
				shift_in('0, '0);
			end
			for (int a = 0; a < HIST; a++) begin
				hist_i[a] = '0;
				hist_q[a] = '0;
			end
		end
	endtask

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("%0t mismatch: %s got %0d expected %0d", $time, what, got, want);
		fails++;
	endtask

	task automatic check_word();
		filt_word_t want;
		logic signed [SW-1:0] got_i, got_q;
		got_i = m_tdata[SW-1:0];
		got_q = m_tdata[2*SW-1:SW];
		if (expected_words.size() == 0) begin
			report_mismatch("unexpected output word, i", got_i, 0);
			return;
		end
		want = expected_words.pop_front();
		if (got_i !== want.fi) report_mismatch("filtered_i", got_i, want.fi);
		if (got_q !== want.fq) report_mismatch("filtered_q", got_q, want.fq);
		if (m_tuser[0] !== want.sat) report_mismatch("saturated", m_tuser[0], want.sat);
		if (m_tlast !== want.last) report_mismatch("last_of_frame", m_tlast, want.last);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				predict_sample(s_tdata[SW-1:0], s_tdata[2*SW-1:SW], s_tlast);
			if (m_tvalid && m_tready)
				check_word();
			pending = expected_words.size();
		end
	end

endmodule

### tb/tb_rrc_interpolating_fir_x2.sv
`timescale 1ns / 100ps
// Testbench top for the 2x interpolating RRC filter: stimulus, flow control and verdict.
module tb_rrc_interpolating_fir_x2
	import rrc_pkg::*;
();

	localparam int SW     = SAMPLE_WIDTH_DEF;
	localparam int DATA_W = ((2 * SW + 7) / 8) * 8;
	localparam int N_ITEMS = 420;

	logic              clk      = 1'b0;
	logic              arst_n   = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [DATA_W-1:0] s_tdata  = '0;
	logic              s_tlast  = 1'b0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [DATA_W-1:0] m_tdata;
	logic [0:0]        m_tuser;
	logic              m_tlast;
	int                fails;
	int                pending;
	int                sent = 0;
	int                stall_mode = 0;
	int                stall_left = 0;

	always #5 clk = ~clk;

	rrc_interpolating_fir_x2 u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	rrc_fir_checker #(.DATA_W(DATA_W)) u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast), .fails(fails), .pending(pending)
	);

	// receiver: stretches of always-ready, light stalls, heavy stalls and full stops
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = (stall_mode == 3) ? $urandom_range(1, 20) : $urandom_range(5, 60);
		end
		stall_left--;
		case (stall_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= ($urandom_range(0, 3) != 0);
			2: m_tready <= ($urandom_range(0, 3) == 0);
			default: m_tready <= 1'b0;
		endcase
	end

	task automatic send_sample(input logic signed [SW-1:0] si, input logic signed [SW-1:0] sq,
			input logic eof);
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= {sq, si};
		s_tlast  <= eof;
		do @(posedge clk); while (!s_tready);
		sent++;
	endtask

	task automatic hold_off(input int cycles);
		if (cycles > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (cycles - 1) @(negedge clk);
		end
	endtask

	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	function automatic logic signed [SW-1:0] pick_sample();
		logic signed [SW-1:0] v;
		case ($urandom_range(0, 9))
			6, 7: v = SW'($urandom_range(0, 600) - 300);
			8: v = 16'sh7fff;
			9: v = 16'sh8000;
			default: v = SW'($urandom);
		endcase
		return v;
	endfunction

	initial begin
		#20_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		int frame_len, burst_left;
		bit quiet;
		bit sign_pat [11];

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// extremes, frame of one, back-to-back frame ends
		send_sample(16'sh0000, 16'sh0000, 1'b0);
		send_sample(16'sh7fff, 16'sh8000, 1'b0);
		send_sample(16'sh8000, 16'sh7fff, 1'b1);
		send_sample(16'sh4000, -16'sh4000, 1'b1);
		// signs matched to the branch-0 taps: drives saturation, then the tail
		sign_pat = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1};
		for (int k = 0; k < 11; k++) begin
			send_sample(sign_pat[k] ? 16'sh8000 : 16'sh7fff,
				sign_pat[k] ? 16'sh7fff : 16'sh8000, k == 10);
		end
		// rounding near zero and alternating bit patterns
		send_sample(-16'sd1, 16'sd1, 1'b0);
		send_sample(16'sd1, -16'sd1, 1'b0);
		send_sample(16'sh5555, 16'shaaaa, 1'b0);
		send_sample(16'shaaaa, 16'sh5555, 1'b1);
		drain();

		burst_left = 0;
		while (sent < N_ITEMS) begin
			frame_len = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
				: $urandom_range(1, 12);
			if (frame_len > N_ITEMS - sent) frame_len = N_ITEMS - sent;
			quiet = ($urandom_range(0, 3) == 0);
			for (int k = 0; k < frame_len; k++) begin
				if (!quiet && burst_left == 0) begin
					hold_off(($urandom_range(0, 5) == 0) ? $urandom_range(10, 30)
						: $urandom_range(0, 4));
					burst_left = $urandom_range(1, 12);
				end
				if (burst_left > 0) burst_left--;
				send_sample(pick_sample(), pick_sample(), k == frame_len - 1);
			end
			if ($urandom_range(0, 5) == 0) drain();
		end

		drain();
		repeat (40) @(negedge clk);
		if (fails == 0 && pending == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
